@@ design/bcd_clock_with_setup_and_display_scan_unit_assert.svh @@
// ----------------------------------------------------------------------------
// BCD clock assertion macros
// Concurrent assertion wrappers on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_WITH_SETUP_AND_DISPLAY_SCAN_UNIT_ASSERT_SVH
`define BCD_CLOCK_WITH_SETUP_AND_DISPLAY_SCAN_UNIT_ASSERT_SVH

// check prop on every clk edge outside reset
`define BCDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check prop on every clk edge, reset included
`define BCDC_ASSERT_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bcdc_pkg.sv @@
// ----------------------------------------------------------------------------
// BCD clock package
// Shared codes, limits, reset values and decode helpers.
// ----------------------------------------------------------------------------
package bcdc_pkg;

	localparam int DIGIT_COUNT = 6;

	localparam logic [7:0] HOURS_WRAP    = 8'h24;
	localparam logic [7:0] LIMIT_MINSEC  = 8'h60;
	localparam logic [5:0] DIGIT_MASK    = 6'h3F;
	localparam logic [7:0] BLINK_RESET   = 8'd150;
	localparam logic [7:0] AUTOINC_RESET = 8'd2;
	localparam logic [7:0] SEG_RESET     = 8'hFF;
	localparam logic [2:0] LAST_DIGIT    = 3'(DIGIT_COUNT - 1);

	typedef enum logic [1:0] {
		ACT_SECOND  = 2'd0,
		ACT_REFRESH = 2'd1,
		ACT_SETUP   = 2'd2,
		ACT_PLUS    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_RUN      = 2'd0,
		MODE_EDIT_SEC = 2'd1,
		MODE_EDIT_MIN = 2'd2,
		MODE_EDIT_HRS = 2'd3
	} mode_t;

	localparam logic CFG_BLINK_PERIOD  = 1'b0;
	localparam logic CFG_AUTOINC_DELAY = 1'b1;

	typedef struct packed {
		logic [7:0] seg;
		logic [5:0] en;
	} disp_t;

	// bit 7 flags wrap to zero
	function automatic logic [7:0] bcd_inc(input logic [6:0] val, input logic [7:0] limit);
		logic [7:0] v;
		v = {1'b0, val} + 8'd1;
		if (v[3:0] == 4'hA)
			v = v + 8'h06;
		if (v == limit)
			return 8'h80;
		return {1'b0, v[6:0]};
	endfunction

	function automatic logic [6:0] seg_decode(input logic [3:0] nib);
		case (nib)
			4'd0: return 7'h3F;
			4'd1: return 7'h06;
			4'd2: return 7'h5B;
			4'd3: return 7'h4F;
			4'd4: return 7'h66;
			4'd5: return 7'h6D;
			4'd6: return 7'h7D;
			4'd7: return 7'h07;
			4'd8: return 7'h7F;
			4'd9: return 7'h6F;
			default: return 7'h00;
		endcase
	endfunction

	function automatic logic [5:0] edit_mask(input mode_t mode);
		case (mode)
			MODE_EDIT_SEC: return 6'b000011;
			MODE_EDIT_MIN: return 6'b001100;
			MODE_EDIT_HRS: return 6'b110000;
			default:       return 6'b000000;
		endcase
	endfunction

endpackage

@@ design/bcdc_digit.sv @@
// ----------------------------------------------------------------------------
// BCD clock digit decode
// Segment byte and blink-gated digit enable for one scan position.
// ----------------------------------------------------------------------------
module bcdc_digit (
	input  logic [2:0]    scan,
	input  logic [6:0]    seconds,
	input  logic [6:0]    minutes,
	input  logic [5:0]    hours,
	input  logic [5:0]    blink_mask,
	output bcdc_pkg::disp_t disp
);

	logic [6:0] fld;
	logic [3:0] nib;
	logic       point;
	logic [7:0] sel;

	always_comb begin
		case (scan[2:1])
			2'd0: fld = seconds;
			2'd1: fld = minutes;
			2'd2: fld = {1'b0, hours};
			default: fld = 7'd0;
		endcase
		nib   = scan[0] ? {1'b0, fld[6:4]} : fld[3:0];
		point = !scan[0] && (scan[2:1] != 2'd0);
		sel   = 8'd1 << scan;
		disp.seg = {point, bcdc_pkg::seg_decode(nib)};
		disp.en  = sel[5:0] & blink_mask;
	end

endmodule

@@ design/bcd_clock_with_setup_and_display_scan_unit.sv @@
// ----------------------------------------------------------------------------
// BCD clock with setup and display scan
// Event-driven time keeping, edit modes, blink and auto-increment pacing,
// and a six-digit multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | flow
//  ---------+------------------------------------------+--------------------
//  in       | in_valid, in_stall, action, plus_held    | valid/stall, sink
//  out      | out_valid, out_stall, segments,          | valid/stall, source
//           | digit_enable, seconds_bcd, minutes_bcd,  |
//           | hours_bcd, clock_mode                    |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| valid/ready, sink
//
// One word per clock sustained while the output is not stalled; a word's result
// is registered in the input register at acceptance, then in the state and result
// registers. Reset is asynchronous; cfg_ready is always high.
// A stalled output holds the event stage, which raises in_stall while it holds a word.
// ----------------------------------------------------------------------------
module bcd_clock_with_setup_and_display_scan_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic       plus_held,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segments,
	output logic [5:0] digit_enable,
	output logic [6:0] seconds_bcd,
	output logic [6:0] minutes_bcd,
	output logic [5:0] hours_bcd,
	output logic [1:0] clock_mode,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic                valid_s1;
	bcdc_pkg::action_t   action_s1;
	logic                held_s1;
	logic                adv;

	logic [7:0]      blink_q, auto_q;
	logic [6:0]      sec_q, min_q, sec_n, min_n;
	logic [5:0]      hrs_q, hrs_n;
	bcdc_pkg::mode_t mode_q, mode_n;
	logic [2:0]      scan_q, scan_n;
	logic [5:0]      act_q, act_n, pend_q, pend_n;
	logic [7:0]      rc_q, rc_n, hc_q, hc_n;
	logic [7:0]      seg_q, seg_n;
	logic [5:0]      en_q, en_n;
	logic            out_valid_q;

	logic [7:0]      sec_inc, min_inc, hrs_inc, rc_inc;
	logic            do_edit;
	bcdc_pkg::disp_t disp;

	bcdc_digit u_digit (
		.scan       (scan_q),
		.seconds    (sec_q),
		.minutes    (min_q),
		.hours      (hrs_q),
		.blink_mask (act_q),
		.disp       (disp)
	);

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			action_s1 <= bcdc_pkg::action_t'(action);
			held_s1   <= plus_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_q <= bcdc_pkg::BLINK_RESET;
			auto_q  <= bcdc_pkg::AUTOINC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcdc_pkg::CFG_BLINK_PERIOD:  blink_q <= cfg_data;
				bcdc_pkg::CFG_AUTOINC_DELAY: auto_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		sec_inc = bcdc_pkg::bcd_inc(sec_q, bcdc_pkg::LIMIT_MINSEC);
		min_inc = bcdc_pkg::bcd_inc(min_q, bcdc_pkg::LIMIT_MINSEC);
		hrs_inc = bcdc_pkg::bcd_inc({1'b0, hrs_q}, bcdc_pkg::HOURS_WRAP);
		rc_inc  = rc_q + 8'd1;

		sec_n   = sec_q;
		min_n   = min_q;
		hrs_n   = hrs_q;
		mode_n  = mode_q;
		scan_n  = scan_q;
		act_n   = act_q;
		pend_n  = pend_q;
		rc_n    = rc_q;
		hc_n    = hc_q;
		seg_n   = seg_q;
		en_n    = en_q;
		do_edit = 1'b0;

		case (action_s1)
			bcdc_pkg::ACT_SECOND: begin
				if (mode_q == bcdc_pkg::MODE_RUN) begin
					sec_n = sec_inc[6:0];
					if (sec_inc[7]) begin
						min_n = min_inc[6:0];
						if (min_inc[7])
							hrs_n = hrs_inc[5:0];
					end
				end
			end
			bcdc_pkg::ACT_REFRESH: begin
				seg_n = disp.seg;
				en_n  = disp.en;
				if (scan_q >= bcdc_pkg::LAST_DIGIT) begin
					act_n  = pend_q;
					scan_n = 3'd0;
				end else begin
					scan_n = scan_q + 3'd1;
				end
				if (mode_q != bcdc_pkg::MODE_RUN) begin
					rc_n = rc_inc;
					if (rc_inc == blink_q) begin
						rc_n = 8'd0;
						if (!held_s1) begin
							pend_n = pend_q ^ bcdc_pkg::edit_mask(mode_q);
							hc_n   = 8'd0;
						end else begin
							if (hc_q == auto_q)
								do_edit = 1'b1;
							else
								hc_n = hc_q + 8'd1;
							pend_n = bcdc_pkg::DIGIT_MASK;
						end
					end
				end
			end
			bcdc_pkg::ACT_SETUP: begin
				case (mode_q)
					bcdc_pkg::MODE_RUN:      mode_n = bcdc_pkg::MODE_EDIT_HRS;
					bcdc_pkg::MODE_EDIT_HRS: mode_n = bcdc_pkg::MODE_EDIT_MIN;
					bcdc_pkg::MODE_EDIT_MIN: mode_n = bcdc_pkg::MODE_EDIT_SEC;
					default:                 mode_n = bcdc_pkg::MODE_RUN;
				endcase
				pend_n = bcdc_pkg::DIGIT_MASK;
				rc_n   = 8'd0;
			end
			default: begin
				if (mode_q != bcdc_pkg::MODE_RUN) begin
					do_edit = 1'b1;
					pend_n  = bcdc_pkg::DIGIT_MASK;
					rc_n    = 8'd0;
				end
			end
		endcase

		if (do_edit) begin
			case (mode_q)
				bcdc_pkg::MODE_EDIT_HRS: hrs_n = hrs_inc[5:0];
				bcdc_pkg::MODE_EDIT_MIN: min_n = min_inc[6:0];
				default:                 sec_n = sec_inc[6:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= 7'd0;
			min_q  <= 7'd0;
			hrs_q  <= 6'd0;
			mode_q <= bcdc_pkg::MODE_EDIT_HRS;
			scan_q <= 3'd0;
			act_q  <= bcdc_pkg::DIGIT_MASK;
			pend_q <= bcdc_pkg::DIGIT_MASK;
			rc_q   <= 8'd0;
			hc_q   <= 8'd0;
			seg_q  <= bcdc_pkg::SEG_RESET;
			en_q   <= bcdc_pkg::DIGIT_MASK;
		end else if (valid_s1 && adv) begin
			sec_q  <= sec_n;
			min_q  <= min_n;
			hrs_q  <= hrs_n;
			mode_q <= mode_n;
			scan_q <= scan_n;
			act_q  <= act_n;
			pend_q <= pend_n;
			rc_q   <= rc_n;
			hc_q   <= hc_n;
			seg_q  <= seg_n;
			en_q   <= en_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign segments     = seg_q;
	assign digit_enable = en_q;
	assign seconds_bcd  = sec_q;
	assign minutes_bcd  = min_q;
	assign hours_bcd    = hrs_q;
	assign clock_mode   = 2'(mode_q);

`include "bcd_clock_with_setup_and_display_scan_unit_assert.svh"

	`BCDC_ASSERT(a_sec_range, (sec_q < 7'h60) && (sec_q[3:0] <= 4'd9), "seconds not valid BCD")
	`BCDC_ASSERT(a_min_range, (min_q < 7'h60) && (min_q[3:0] <= 4'd9), "minutes not valid BCD")
	`BCDC_ASSERT(a_hrs_range, (hrs_q < 6'h24) && (hrs_q[3:0] <= 4'd9), "hours not valid BCD")
	`BCDC_ASSERT_ALL(a_scan_range, scan_q <= bcdc_pkg::LAST_DIGIT, "scan digit out of range")
	`BCDC_ASSERT(a_run_unmasked, (mode_q == bcdc_pkg::MODE_RUN) |-> (pend_q == bcdc_pkg::DIGIT_MASK), "blink mask pending in run mode")
	`BCDC_ASSERT(a_stage_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(action_s1)), "event stage dropped a stalled word")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BCD clock testbench
// Drives second, refresh, setup and plus events through the valid/stall input,
// predicts every readout word from an internal clock, scan and blink model, and
// compares it field by field with the block's output under varied pacing.
// ----------------------------------------------------------------------------
module tb;

	import bcdc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_GAP       = 4;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int MAX_REPORTS     = 10;

	// seven-segment patterns for digits 0..9, digit 0 in the low bits
	localparam logic [69:0] SEVEN_SEG_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

	typedef struct packed {
		logic [7:0] segments;
		logic [5:0] digit_enable;
		logic [6:0] seconds;
		logic [6:0] minutes;
		logic [5:0] hours;
		mode_t      mode;
	} readout_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] action;
	logic       plus_held;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] segments;
	logic [5:0] digit_enable;
	logic [6:0] seconds_bcd;
	logic [6:0] minutes_bcd;
	logic [5:0] hours_bcd;
	logic [1:0] clock_mode;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_index;
	logic [7:0] cfg_data;

	// clock model state
	logic [7:0] sim_sec, sim_min, sim_hrs;
	mode_t      sim_mode;
	logic [2:0] scan_pos;
	logic [5:0] lit_mask, next_mask;
	logic [7:0] tick_cnt, hold_cnt;
	logic [7:0] seg_out;
	logic [5:0] en_out;
	logic [7:0] blink_len, hold_delay;

	readout_t pending_readout[$];
	int       bad_readouts;
	int       words_sent;
	int       cycle_count;
	int       src_idle_pct;
	int       rx_stall_pct;
	int       hold_off_requests;

	bcd_clock_with_setup_and_display_scan_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.plus_held    (plus_held),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.digit_enable (digit_enable),
		.seconds_bcd  (seconds_bcd),
		.minutes_bcd  (minutes_bcd),
		.hours_bcd    (hours_bcd),
		.clock_mode   (clock_mode),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic logic [7:0] bcd_next(input logic [7:0] cur, input logic [7:0] wrap_at);
		logic [7:0] v;
		v = cur + 8'd1;
		if (v[3:0] == 4'hA)
			v = v + 8'h06;
		if (v == wrap_at)
			v = 8'h00;
		return {1'b0, v[6:0]};
	endfunction

	function automatic logic [6:0] seven_seg(input logic [3:0] nib);
		if (nib > 4'd9)
			return 7'h00;
		return SEVEN_SEG_ROM[nib * 7 +: 7];
	endfunction

	task automatic bump_edited();
		case (sim_mode)
			MODE_EDIT_HRS: sim_hrs = bcd_next(sim_hrs, HOURS_WRAP);
			MODE_EDIT_MIN: sim_min = bcd_next(sim_min, LIMIT_MINSEC);
			default:       sim_sec = bcd_next(sim_sec, LIMIT_MINSEC);
		endcase
	endtask

	task automatic scan_refresh(input logic held);
		logic [7:0] fld;
		logic [3:0] nib;
		case (scan_pos[2:1])
			2'd0:    fld = sim_sec;
			2'd1:    fld = sim_min;
			2'd2:    fld = sim_hrs;
			default: fld = 8'h00;
		endcase
		nib = scan_pos[0] ? fld[7:4] : fld[3:0];
		seg_out = {(!scan_pos[0] && scan_pos[2:1] != 2'd0), seven_seg(nib)};
		en_out = 6'(8'd1 << scan_pos) & lit_mask;
		if (scan_pos >= LAST_DIGIT) begin
			lit_mask = next_mask;
			scan_pos = 3'd0;
		end else begin
			scan_pos = scan_pos + 3'd1;
		end
		if (sim_mode == MODE_RUN)
			return;
		tick_cnt = tick_cnt + 8'd1;
		if (tick_cnt == blink_len) begin
			if (!held) begin
				next_mask ^= 6'd3 << {sim_mode - 2'd1, 1'b0};
				hold_cnt = 8'd0;
			end else begin
				if (hold_cnt == hold_delay)
					bump_edited();
				else
					hold_cnt = hold_cnt + 8'd1;
				next_mask = DIGIT_MASK;
			end
			tick_cnt = 8'd0;
		end
	endtask

	task automatic clock_event(input action_t act, input logic held);
		readout_t r;
		case (act)
			ACT_SECOND: begin
				if (sim_mode == MODE_RUN) begin
					sim_sec = bcd_next(sim_sec, LIMIT_MINSEC);
					if (sim_sec == 8'h00) begin
						sim_min = bcd_next(sim_min, LIMIT_MINSEC);
						if (sim_min == 8'h00)
							sim_hrs = bcd_next(sim_hrs, HOURS_WRAP);
					end
				end
			end
			ACT_REFRESH: scan_refresh(held);
			ACT_SETUP: begin
				sim_mode = (sim_mode == MODE_RUN) ? MODE_EDIT_HRS : mode_t'(sim_mode - 2'd1);
				next_mask = DIGIT_MASK;
				tick_cnt = 8'd0;
			end
			default: begin
				if (sim_mode != MODE_RUN) begin
					bump_edited();
					next_mask = DIGIT_MASK;
					tick_cnt = 8'd0;
				end
			end
		endcase
		r.segments = seg_out;
		r.digit_enable = en_out;
		r.seconds = sim_sec[6:0];
		r.minutes = sim_min[6:0];
		r.hours = sim_hrs[5:0];
		r.mode = sim_mode;
		pending_readout.push_back(r);
	endtask

	task automatic log_miss(input string what, input int want, input int got);
		bad_readouts++;
		if (bad_readouts <= MAX_REPORTS)
			$display("mismatch %s: expected %0h got %0h", what, want, got);
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got)
			log_miss(what, want, got);
	endtask

	always @(posedge clk) begin : watch_readout
		readout_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readout.size() == 0) begin
				log_miss("unexpected word", 0, 0);
			end else begin
				want = pending_readout.pop_front();
				check_field("segments", want.segments, segments);
				check_field("digit_enable", want.digit_enable, digit_enable);
				check_field("seconds_bcd", want.seconds, seconds_bcd);
				check_field("minutes_bcd", want.minutes, minutes_bcd);
				check_field("hours_bcd", want.hours, hours_bcd);
				check_field("clock_mode", want.mode, clock_mode);
			end
		end
	end

	// output stall: random stalls, plus long hold-offs on request
	initial begin
		int held_for;
		int served;
		held_for = 0;
		served = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (served < hold_off_requests) begin
				out_stall <= 1'b1;
				held_for++;
				if (held_for == HOLD_OFF_CYCLES) begin
					held_for = 0;
					served++;
				end
			end else begin
				out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	task automatic send_word(input action_t act, input logic held);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		plus_held <= held;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		clock_event(act, held);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_readout.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic load_config(input logic [7:0] blink, input logic [7:0] delay);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_BLINK_PERIOD;
		cfg_data <= blink;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		blink_len = blink;
		cfg_index <= CFG_AUTOINC_DELAY;
		cfg_data <= delay;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		hold_delay = delay;
		cfg_valid <= 1'b0;
	endtask

	task automatic goto_mode(input mode_t target);
		while (sim_mode != target)
			send_word(ACT_SETUP, 1'($urandom_range(1)));
	endtask

	task automatic press_until(input logic [7:0] target);
		logic [7:0] cur;
		cur = (sim_mode == MODE_EDIT_HRS) ? sim_hrs :
			(sim_mode == MODE_EDIT_MIN) ? sim_min : sim_sec;
		while (cur != target) begin
			send_word(ACT_PLUS, 1'($urandom_range(1)));
			cur = (sim_mode == MODE_EDIT_HRS) ? sim_hrs :
				(sim_mode == MODE_EDIT_MIN) ? sim_min : sim_sec;
		end
	endtask

	task automatic set_pacing(input int src_pct, input int rx_pct);
		src_idle_pct = src_pct;
		rx_stall_pct = rx_pct;
	endtask

	task automatic test_reset_scan();
		set_pacing(0, 0);
		for (int i = 0; i < 6; i++)
			send_word(ACT_REFRESH, 1'(i % 2));
		send_word(ACT_SECOND, 1'b0);
		send_word(ACT_PLUS, 1'b0);
		send_word(ACT_PLUS, 1'b1);
		send_word(ACT_SETUP, 1'b0);
		send_word(ACT_PLUS, 1'b0);
		send_word(ACT_SETUP, 1'b1);
		send_word(ACT_PLUS, 1'b1);
		send_word(ACT_SETUP, 1'b0);
		send_word(ACT_PLUS, 1'b0);
		send_word(ACT_SECOND, 1'b1);
		send_word(ACT_SECOND, 1'b0);
		send_word(ACT_REFRESH, 1'b1);
		send_word(ACT_REFRESH, 1'b0);
	endtask

	task automatic test_blink_autoinc();
		load_config(8'd1, 8'd0);
		send_word(ACT_SETUP, 1'b0);
		send_word(ACT_REFRESH, 1'b0);
		send_word(ACT_REFRESH, 1'b1);
		send_word(ACT_REFRESH, 1'b1);
		send_word(ACT_REFRESH, 1'b0);
	endtask

	task automatic test_day_wrap();
		load_config(8'd150, 8'd2);
		set_pacing(82, 0);
		goto_mode(MODE_EDIT_HRS);
		press_until(8'h23);
		goto_mode(MODE_EDIT_MIN);
		press_until(8'h59);
		goto_mode(MODE_EDIT_SEC);
		press_until(8'h57);
		goto_mode(MODE_RUN);
		repeat (4) send_word(ACT_SECOND, 1'($urandom_range(1)));
	endtask

	task automatic test_blink_extremes();
		load_config(8'd255, 8'd255);
		set_pacing(29, 29);
		goto_mode(MODE_EDIT_MIN);
		repeat (260) send_word(ACT_REFRESH, 1'b0);
		load_config(8'd0, 8'd0);
		goto_mode(MODE_EDIT_SEC);
		repeat (260) send_word(ACT_REFRESH, 1'b1);
	endtask

	task automatic mix_phase(input logic [7:0] blink, input logic [7:0] delay,
			input int src_pct, input int rx_pct, input int count);
		int start;
		int pick;
		int len;
		int run;
		logic held;
		load_config(blink, delay);
		set_pacing(src_pct, rx_pct);
		start = words_sent;
		while (words_sent - start < count) begin
			pick = $urandom_range(99);
			len = $urandom_range(20, 2);
			if (pick < 35) begin
				// blink and hold pacing in an edit mode
				if (sim_mode == MODE_RUN)
					send_word(ACT_SETUP, 1'b0);
				held = 1'($urandom_range(1));
				run = 0;
				repeat (len) begin
					if (run == 0) begin
						held = ~held;
						run = $urandom_range(8, 1);
					end
					run--;
					send_word(ACT_REFRESH, held);
				end
			end else if (pick < 60) begin
				goto_mode(MODE_RUN);
				repeat (len * 2)
					send_word($urandom_range(3) == 0 ? ACT_REFRESH : ACT_SECOND,
						1'($urandom_range(1)));
			end else if (pick < 75) begin
				if (sim_mode == MODE_RUN)
					send_word(ACT_SETUP, 1'b1);
				repeat (len)
					send_word(ACT_PLUS, 1'($urandom_range(1)));
			end else begin
				repeat (len)
					send_word(action_t'($urandom_range(3)), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_random_mix();
		mix_phase(8'd1, 8'd0, 0, 0, 40);
		mix_phase(8'd2, 8'd1, 82, 0, 30);
		mix_phase(8'd1, 8'd255, 0, 82, 30);
		mix_phase(8'd3, 8'd3, 29, 29, 30);
		mix_phase(8'd5, 8'd2, 0, 0, 20);
	endtask

	task automatic test_backpressure();
		load_config(8'd2, 8'd1);
		set_pacing(0, 0);
		hold_off_requests++;
		repeat (40)
			send_word(action_t'($urandom_range(3)), 1'($urandom_range(1)));
	endtask

	initial begin
		sim_sec = 8'h00;
		sim_min = 8'h00;
		sim_hrs = 8'h00;
		sim_mode = MODE_EDIT_HRS;
		scan_pos = 3'd0;
		lit_mask = DIGIT_MASK;
		next_mask = DIGIT_MASK;
		tick_cnt = 8'd0;
		hold_cnt = 8'd0;
		seg_out = SEG_RESET;
		en_out = DIGIT_MASK;
		blink_len = BLINK_RESET;
		hold_delay = AUTOINC_RESET;
		bad_readouts = 0;
		words_sent = 0;
		cycle_count = 0;
		src_idle_pct = 0;
		rx_stall_pct = 0;
		hold_off_requests = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= ACT_SECOND;
		plus_held <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_BLINK_PERIOD;
		cfg_data <= 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_scan();
		test_blink_autoinc();
		test_day_wrap();
		test_blink_extremes();
		test_random_mix();
		test_backpressure();

		wait_drained();
		if (bad_readouts == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
